// ----- design/mdfm_pkg.sv -----
// mdfm_pkg: shared types and constants for the motor drive fault monitor
// holds mode codes, register indexes, flag positions and the word structs
// no dependencies
`default_nettype none

package mdfm_pkg;

    // item mode codes
    localparam logic [2:0] MODE_CURRENT = 3'd0;
    localparam logic [2:0] MODE_BUS     = 3'd1;
    localparam logic [2:0] MODE_HW      = 3'd2;
    localparam logic [2:0] MODE_TEMP    = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [2:0] REG_BUS_RATED     = 3'd1;
    localparam logic [2:0] REG_BUS_MARGIN    = 3'd2;
    localparam logic [2:0] REG_BUS_LOW_LIMIT = 3'd3;
    localparam logic [2:0] REG_TEMP_LIMIT    = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] BUS_LOW_RESET = 16'd2000;

    // flag bit positions
    localparam int FLAG_AVG  = 0;
    localparam int FLAG_MAX  = 1;
    localparam int FLAG_OVER = 2;
    localparam int FLAG_LOW  = 3;
    localparam int FLAG_HW   = 4;
    localparam int FLAG_HEAT = 5;
    localparam int FLAG_W    = 6;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [14:0] current_limit;
        logic [15:0] bus_rated;
        logic [15:0] bus_margin;
        logic [15:0] bus_low_limit;
        logic [14:0] temp_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
        logic [15:0]        bus_sample;
        logic signed [15:0] temp_sample;
        logic               hw_ok;
    } item_t;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic              group_trip;
        logic              any_fault;
        logic              fan_on;
    } result_t;

endpackage

`default_nettype wire

// ----- design/motor_drive_fault_monitor.sv -----
// motor_drive_fault_monitor: top level with input word register and result register
// depends on mdfm_pkg, mdfm_cfg_regs and mdfm_fault_core
//
// The monitor takes one word per clock on the s_ stream, unless s_tready is held low,
// and returns one result word per input word on the m_ stream, in order. An accepted
// word sits in the input register while the fault core evaluates it; the result
// register captures flags, trip, any-fault and fan drive when the word moves on and
// raises m_tvalid. Throughput is one word per cycle while m_tready does not stall the
// output; stalls on m_tready back up through the two registers.
// Configuration writes on cfg_we take effect at the next edge and should be made only
// while the stream is idle.
`default_nettype none

module motor_drive_fault_monitor #(
    parameter int TRIP_COUNT = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: phase_a[15:0], phase_b[31:16], phase_c[47:32], bus_sample[63:48],
    //          temp_sample[79:64], hw_ok[80], zero pad[87:81]
    input  wire logic [87:0] s_tdata,
    // s_tuser: mode[2:0]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: flags[5:0], group_trip[6], any_fault[7], fan_on[8], zero pad[15:9]
    output logic [15:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import mdfm_pkg::*;

    cfg_t    cfg;
    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    result_t core_res;
    result_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;
    logic    s_accept, advance;

    mdfm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mdfm_fault_core #(.TRIP_COUNT(TRIP_COUNT)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (core_res)
    );

    // handshake: the word in the input register moves on when the result slot frees
    always_comb begin
        advance  = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready = !in_valid_reg || advance;
        s_accept = s_tvalid && s_tready;
    end

    // unpack the input word
    always_comb begin
        item_next             = item_reg;
        if (s_accept) begin
            item_next.mode        = s_tuser;
            item_next.phase_a     = signed'(s_tdata[15:0]);
            item_next.phase_b     = signed'(s_tdata[31:16]);
            item_next.phase_c     = signed'(s_tdata[47:32]);
            item_next.bus_sample  = s_tdata[63:48];
            item_next.temp_sample = signed'(s_tdata[79:64]);
            item_next.hw_ok       = s_tdata[80];
        end
    end

    // valid bits and result capture
    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        res_next       = advance ? core_res : res_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.fan_on, res_reg.any_fault, res_reg.group_trip,
                       res_reg.flags};

    // a clear word always reports all flags down
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item_reg.mode == MODE_CLEAR) |=> (m_tdata[5:0] == 6'd0))
        else $error("flags not cleared by clear word");

    // hardware and clear words never report a group trip
    a_no_group: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ((item_reg.mode == MODE_HW) || (item_reg.mode == MODE_CLEAR))
        |=> !m_tdata[6])
        else $error("group trip on a mode without a group");

    // input stalls only when both registers are full and the sink holds off
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // any-fault follows the reported flags
    a_any_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == (m_tdata[5:0] != 6'd0)))
        else $error("any-fault disagrees with flags");

endmodule

`default_nettype wire

// ----- design/mdfm_cfg_regs.sv -----
// mdfm_cfg_regs: configuration register file of the fault monitor
// depends on mdfm_pkg for register indexes and the cfg_t struct
`default_nettype none

module mdfm_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mdfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mdfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mdfm_pkg::cfg_t                      cfg
);
    import mdfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_CURRENT_LIMIT: cfg_next.current_limit = cfg_wdata[14:0];
                REG_BUS_RATED:     cfg_next.bus_rated     = cfg_wdata;
                REG_BUS_MARGIN:    cfg_next.bus_margin    = cfg_wdata;
                REG_BUS_LOW_LIMIT: cfg_next.bus_low_limit = cfg_wdata;
                REG_TEMP_LIMIT:    cfg_next.temp_limit    = cfg_wdata[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_limit <= '0;
            cfg_reg.bus_rated     <= '0;
            cfg_reg.bus_margin    <= '0;
            cfg_reg.bus_low_limit <= BUS_LOW_RESET;
            cfg_reg.temp_limit    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/mdfm_fault_core.sv -----
// mdfm_fault_core: limit checks, sticky flags, near-limit counter and fan hysteresis
// depends on mdfm_pkg for mode codes, flag positions and word structs
`default_nettype none

module mdfm_fault_core #(
    parameter int TRIP_COUNT = 10
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    update,
    input  wire mdfm_pkg::cfg_t  cfg,
    input  wire mdfm_pkg::item_t item,
    output mdfm_pkg::result_t result
);
    import mdfm_pkg::*;

    localparam int CNT_W = $clog2(TRIP_COUNT + 2);
    localparam logic [CNT_W-1:0] TRIP_LIMIT = CNT_W'(TRIP_COUNT);

    logic [FLAG_W-1:0] fault_bits_reg, fault_bits_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              fan_reg, fan_next;

    logic [15:0] mag_a, mag_b, mag_c;
    logic [18:0] near_thr;
    logic        near_hit, max_hit;
    logic [16:0] over_thr;
    logic signed [21:0] t_ext, lim_ext;
    logic [CNT_W-1:0] count_inc;
    logic        group;

    // magnitudes of the phase currents, -32768 maps to 32768
    always_comb begin
        mag_a = item.phase_a[15] ? 16'(-item.phase_a) : 16'(item.phase_a);
        mag_b = item.phase_b[15] ? 16'(-item.phase_b) : 16'(item.phase_b);
        mag_c = item.phase_c[15] ? 16'(-item.phase_c) : 16'(item.phase_c);
    end

    // current thresholds: 10|x| > 9*limit and |x| > limit
    always_comb begin
        near_thr = 19'(cfg.current_limit) * 19'd9;
        near_hit = (19'(mag_a) * 19'd10 > near_thr)
                || (19'(mag_b) * 19'd10 > near_thr)
                || (19'(mag_c) * 19'd10 > near_thr);
        max_hit  = (mag_a > 16'(cfg.current_limit))
                || (mag_b > 16'(cfg.current_limit))
                || (mag_c > 16'(cfg.current_limit));
        count_inc = count_reg + CNT_W'(1);
    end

    // bus and temperature operands
    always_comb begin
        over_thr = 17'(cfg.bus_rated) + 17'(cfg.bus_margin);
        t_ext    = 22'(item.temp_sample);
        lim_ext  = signed'(22'(cfg.temp_limit));
    end

    // next state and result for the item
    always_comb begin
        fault_bits_next = fault_bits_reg;
        count_next      = count_reg;
        fan_next        = fan_reg;
        group           = 1'b0;
        case (item.mode)
            MODE_CURRENT: begin
                if (near_hit) begin
                    if (count_inc > TRIP_LIMIT) begin
                        fault_bits_next[FLAG_AVG] = 1'b1;
                        count_next = '0;
                    end else begin
                        count_next = count_inc;
                    end
                end
                if (max_hit) fault_bits_next[FLAG_MAX] = 1'b1;
                group = fault_bits_next[FLAG_AVG] | fault_bits_next[FLAG_MAX];
            end
            MODE_BUS: begin
                if (17'(item.bus_sample) > over_thr) fault_bits_next[FLAG_OVER] = 1'b1;
                if (item.bus_sample < cfg.bus_low_limit) fault_bits_next[FLAG_LOW] = 1'b1;
                group = fault_bits_next[FLAG_OVER] | fault_bits_next[FLAG_LOW];
            end
            MODE_HW: begin
                if (!item.hw_ok) fault_bits_next[FLAG_HW] = 1'b1;
            end
            MODE_TEMP: begin
                if (t_ext > lim_ext) fault_bits_next[FLAG_HEAT] = 1'b1;
                // turn-off test wins when both hold
                if (t_ext * 22'sd5 > lim_ext * 22'sd2) fan_next = 1'b1;
                if (t_ext * 22'sd25 < lim_ext * 22'sd9) fan_next = 1'b0;
                group = fault_bits_next[FLAG_HEAT];
            end
            MODE_CLEAR: begin
                fault_bits_next = '0;
            end
            default: begin
                fault_bits_next = fault_bits_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_bits_reg <= '0;
            count_reg      <= '0;
            fan_reg        <= 1'b0;
        end else if (update) begin
            fault_bits_reg <= fault_bits_next;
            count_reg      <= count_next;
            fan_reg        <= fan_next;
        end
    end

    always_comb begin
        result.flags      = fault_bits_next;
        result.group_trip = group;
        result.any_fault  = |fault_bits_next;
        result.fan_on     = fan_next;
    end

endmodule

`default_nettype wire
